FILE: hdl/nrl_pkg.sv
// ----------------------------------------------------------------------------
// nrl_pkg: shared types and constants for the notification ring log
// Depths, field widths, operation codes and the toast cell control bundle.
// ----------------------------------------------------------------------------
package nrl_pkg;

   localparam int LOG_DEPTH   = 16;
   localparam int TOAST_DEPTH = 8;
   localparam int LOG_AW      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int LOG_FW      = $clog2(LOG_DEPTH + 1);
   localparam int TOAST_FW    = $clog2(TOAST_DEPTH + 1);
   localparam int LOG_W       = 64;
   localparam logic [31:0] LIFETIME_RESET = 32'd5000;

   localparam logic [2:0] KIND_PUSH   = 3'd0;
   localparam logic [2:0] KIND_FIND   = 3'd1;
   localparam logic [2:0] KIND_NEWEST = 3'd2;
   localparam logic [2:0] KIND_REMOVE = 3'd3;
   localparam logic [2:0] KIND_EXPIRE = 3'd4;

   // control broadcast to every toast cell
   typedef struct packed {
      logic        load;    // load the whole row from the input side
      logic        shift;   // hand contents one cell down
      logic        push;    // write the new toast into the tail cell
      logic [TOAST_FW-1:0] tail;
      logic [31:0] id;
      logic [47:0] tm;
   } toast_ctl_type;

endpackage

FILE: hdl/notification_ring_log_with_toasts.sv
// ----------------------------------------------------------------------------
// notification_ring_log_with_toasts: ring log of records with toast list
// Channel | beat fields (low bit up)
// req     | tdata: id, offset, time_ms, payload ; tuser: kind
// rsp     | tdata: ok, rec_id, slot, replaced, rec_payload, toasts_left
// csr     | wdata: toast lifetime
// One item at a time. Push writes the record directly; newest reads one slot;
// find reads slot by slot from the oldest until a match or the whole log is
// searched; remove and expire walk once over the pending toasts. Reset
// synchronous, no clearing pass. A waiting result holds until taken; the next
// beat is accepted only once the result register is free.
// ----------------------------------------------------------------------------
module notification_ring_log_with_toasts import nrl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // id[31:0], offset[39:32], time_ms[87:40], payload[119:88]
   input  logic [2:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,  // ok, rec_id, slot, replaced, rec_payload, toasts_left
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_FIND = 5'b00010, S_READ = 5'b00100,
      S_WALK = 5'b01000, S_DONE = 5'b10000
   } state_type;

   state_type state_ff;
   logic [31:0] life_ff;
   logic [2:0]  kind_ff;
   logic [31:0] qid_ff;
   logic [47:0] now_ff;
   logic [LOG_AW-1:0] head_ff, slot_ff, rslot_ff;
   logic [LOG_FW-1:0] lfill_ff, cnt_ff;
   logic [31:0] last_ff;
   logic [TOAST_FW-1:0] tfill_ff, w_ff, i_ff;
   logic        rvalid_ff;
   logic [87:0] rdata_ff;

   // log RAM
   logic             ram_we;
   logic [LOG_AW-1:0] ram_wa, ram_ra;
   logic [LOG_W-1:0] ram_wd, ram_rd;
   nrl_ram #(.WIDTH(LOG_W), .DEPTH(LOG_DEPTH)) u_log (
      .clock, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
      .raddr(ram_ra), .rdata(ram_rd));

   // toast chain: each cell takes its upper neighbour, cell 0 rotates in last
   toast_ctl_type ctl;
   logic [31:0] cid [TOAST_DEPTH];
   logic [47:0] ctm [TOAST_DEPTH];
   logic [31:0] kid [TOAST_DEPTH];
   logic [47:0] ktm [TOAST_DEPTH];
   logic [31:0] kid_ff [TOAST_DEPTH];
   logic [47:0] ktm_ff [TOAST_DEPTH];
   for (genvar g = 0; g < TOAST_DEPTH; g++) begin : g_cell
      nrl_cell u_cell (
         .clock, .ctl, .index(TOAST_FW'(g)),
         .nbr_id(cid[(g + 1) % TOAST_DEPTH]), .nbr_tm(ctm[(g + 1) % TOAST_DEPTH]),
         .ld_id(kid_ff[g]), .ld_tm(ktm_ff[g]),
         .id_out(cid[g]), .tm_out(ctm[g]));
   end

   wire accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rvalid_ff;
   wire [LOG_AW-1:0] push_slot = (lfill_ff >= LOG_FW'(LOG_DEPTH)) ? head_ff :
        LOG_AW'((LOG_FW'(head_ff) + lfill_ff) % LOG_FW'(LOG_DEPTH));
   wire [31:0] nid_raw = last_ff + 32'd1;
   wire [31:0] nid = (nid_raw == 32'd0) ? 32'd1 : nid_raw;
   wire [31:0] rq_id = req_tdata[31:0];
   wire [7:0]  rq_off = req_tdata[39:32];
   wire [47:0] rq_tm = req_tdata[87:40];
   wire [31:0] rq_pay = req_tdata[119:88];
   wire [LOG_AW-1:0] step_slot = (slot_ff == LOG_AW'(LOG_DEPTH - 1)) ? '0 :
                                 LOG_AW'(slot_ff + 1'b1);

   // keep test on the toast in cell 0 as it rotates past
   wire [48:0] age_d = {1'b0, now_ff} - {1'b0, ctm[0]};
   wire [47:0] age = age_d[48] ? 48'd0 : age_d[47:0];
   wire keep = (kind_ff == KIND_REMOVE) ? (qid_ff == 32'd0 || cid[0] != qid_ff)
                                        : (age < {16'd0, life_ff});

   always_comb begin
      for (int k = 0; k < TOAST_DEPTH; k++) begin
         kid[k] = kid_ff[k];
         ktm[k] = ktm_ff[k];
      end
      if (w_ff < TOAST_FW'(TOAST_DEPTH)) begin
         kid[w_ff[$clog2(TOAST_DEPTH > 1 ? TOAST_DEPTH : 2)-1:0]] = cid[0];
         ktm[w_ff[$clog2(TOAST_DEPTH > 1 ? TOAST_DEPTH : 2)-1:0]] = ctm[0];
      end
   end

   always_comb begin
      ctl = '0;
      ctl.id = nid;
      ctl.tm = rq_tm;
      ram_we = 1'b0;
      ram_wa = push_slot;
      ram_wd = {rq_pay, nid};
      ram_ra = slot_ff;
      if (accept && req_tuser == KIND_PUSH) begin
         ram_we = 1'b1;
         if (tfill_ff < TOAST_FW'(TOAST_DEPTH)) begin
            ctl.push = 1'b1;
            ctl.tail = tfill_ff;
         end else begin
            ctl.shift = 1'b1;
            ctl.push = 1'b1;
            ctl.tail = TOAST_FW'(TOAST_DEPTH - 1);
         end
      end
      if (state_ff == S_WALK) begin
         if (i_ff < tfill_ff) ctl.shift = 1'b1;
         else ctl.load = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         life_ff <= LIFETIME_RESET;
         head_ff <= '0;
         lfill_ff <= '0;
         last_ff <= '0;
         tfill_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_we) life_ff <= csr_wdata;
         if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff <= req_tuser;
                  qid_ff <= rq_id;
                  now_ff <= rq_tm;
                  rdata_ff <= 88'({8'(tfill_ff), 74'd0});
                  unique case (req_tuser)
                     KIND_PUSH: begin
                        last_ff <= nid;
                        if (lfill_ff >= LOG_FW'(LOG_DEPTH))
                           head_ff <= (head_ff == LOG_AW'(LOG_DEPTH - 1)) ? '0 :
                                      LOG_AW'(head_ff + 1'b1);
                        else lfill_ff <= LOG_FW'(lfill_ff + 1'b1);
                        if (tfill_ff < TOAST_FW'(TOAST_DEPTH))
                           tfill_ff <= TOAST_FW'(tfill_ff + 1'b1);
                        rdata_ff <= 88'({8'(((tfill_ff < TOAST_FW'(TOAST_DEPTH)) ?
                                     TOAST_FW'(tfill_ff + 1'b1) : tfill_ff)),
                                     rq_pay, lfill_ff >= LOG_FW'(LOG_DEPTH),
                                     8'(push_slot), nid, 1'b1});
                        state_ff <= S_DONE;
                     end
                     KIND_FIND: begin
                        slot_ff <= head_ff;
                        cnt_ff <= '0;
                        state_ff <= (rq_id == 32'd0 || lfill_ff == '0) ? S_DONE : S_FIND;
                     end
                     KIND_NEWEST: begin
                        if ({1'b0, rq_off} < 9'(lfill_ff)) begin
                           slot_ff <= LOG_AW'((9'(head_ff) + 9'(lfill_ff) - 9'(rq_off)
                                      - 9'd1) % 9'(LOG_DEPTH));
                           state_ff <= S_FIND;
                        end else state_ff <= S_DONE;
                     end
                     KIND_REMOVE, KIND_EXPIRE: begin
                        i_ff <= '0;
                        w_ff <= '0;
                        state_ff <= S_WALK;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            // issue read of slot_ff, then compare in S_READ
            S_FIND: begin
               rslot_ff <= slot_ff;
               state_ff <= S_READ;
            end
            S_READ: begin
               if (kind_ff == KIND_NEWEST || ram_rd[31:0] == qid_ff) begin
                  rdata_ff <= 88'({8'(tfill_ff), ram_rd[63:32], 1'b0,
                               8'((kind_ff == KIND_NEWEST) ? slot_ff : rslot_ff),
                               ram_rd[31:0], 1'b1});
                  state_ff <= S_DONE;
               end else if (LOG_FW'(cnt_ff + 1'b1) >= lfill_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= LOG_FW'(cnt_ff + 1'b1);
                  slot_ff <= step_slot;
                  state_ff <= S_FIND;
               end
            end
            // rotate the chain, gathering kept toasts in order
            S_WALK: begin
               if (i_ff < tfill_ff) begin
                  if (keep) w_ff <= TOAST_FW'(w_ff + 1'b1);
                  for (int k = 0; k < TOAST_DEPTH; k++) begin
                     kid_ff[k] <= keep ? kid[k] : kid_ff[k];
                     ktm_ff[k] <= keep ? ktm[k] : ktm_ff[k];
                  end
                  i_ff <= TOAST_FW'(i_ff + 1'b1);
               end else begin
                  tfill_ff <= w_ff;
                  rdata_ff <= 88'({8'(w_ff), 74'd1});
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rvalid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = rdata_ff;
endmodule

FILE: hdl/nrl_ram.sv
// ----------------------------------------------------------------------------
// nrl_ram: generic simple dual-port RAM with registered read
// One write and one read address each cycle.
// ----------------------------------------------------------------------------
module nrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule

FILE: hdl/nrl_cell.sv
// ----------------------------------------------------------------------------
// nrl_cell: one toast slot of the toast chain
// Holds one id and time; takes its neighbour's contents on a shift.
// ----------------------------------------------------------------------------
module nrl_cell import nrl_pkg::*; (
   input  logic                clock,
   input  toast_ctl_type       ctl,
   input  logic [TOAST_FW-1:0] index,
   input  logic [31:0]         nbr_id,
   input  logic [47:0]         nbr_tm,
   input  logic [31:0]         ld_id,
   input  logic [47:0]         ld_tm,
   output logic [31:0]         id_out,
   output logic [47:0]         tm_out
);
   logic [31:0] id_ff;
   logic [47:0] tm_ff;

   // load, shift or capture the pushed toast
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         id_ff <= ld_id;
         tm_ff <= ld_tm;
      end else if (ctl.push && ctl.tail == index) begin
         id_ff <= ctl.id;
         tm_ff <= ctl.tm;
      end else if (ctl.shift) begin
         id_ff <= nbr_id;
         tm_ff <= nbr_tm;
      end
   end

   assign id_out = id_ff;
   assign tm_out = tm_ff;
endmodule

FILE: hdl/nrl_checker.sv
// ----------------------------------------------------------------------------
// nrl_checker: port-level checks for the notification ring log
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module nrl_checker import nrl_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [87:0]  rsp_tdata
);
   // a waiting result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed");
   // no new beat taken while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("beat accepted while result pending");
   // a push beat reports success with a non-zero id
   a_push: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_PUSH |=> ##1 rsp_tvalid &&
      rsp_tdata[0] && rsp_tdata[32:1] != 32'd0)
      else $error("push result wrong");
   // toast count never exceeds the list depth
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[81:74] <= 8'(TOAST_DEPTH))
      else $error("toast count out of range");
endmodule

bind notification_ring_log_with_toasts nrl_checker u_chk (.*);
